// ===== rtl/m3i_pkg.sv =====
// Package with payload types and constants for the 3x3 matrix inverse.
`default_nettype none
package m3i_pkg;

  typedef struct packed {
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a02;
    logic signed [31:0] a10;
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a20;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
  } m3i_in_t;

  typedef struct packed {
    logic signed [31:0] inv00;
    logic signed [31:0] inv01;
    logic signed [31:0] inv02;
    logic signed [31:0] inv10;
    logic signed [31:0] inv11;
    logic signed [31:0] inv12;
    logic signed [31:0] inv20;
    logic signed [31:0] inv21;
    logic signed [31:0] inv22;
    logic               singular;
    logic               saturated;
  } m3i_out_t;

  // Cofactors fit in 65 bits, the determinant in 97 bits.
  localparam int unsigned CofW = 65;
  localparam int unsigned DetW = 97;
  // Quotient bits kept: enough to see anything above 2^31.
  localparam int unsigned QW = 33;
  // Dividend is |cofactor| (64 bits used) shifted left by 32.
  localparam int unsigned NumW = 96;

  localparam logic [31:0] MaxPos = 32'h7FFF_FFFF;
  localparam logic [31:0] MinNeg = 32'h8000_0000;

endpackage
`default_nettype wire

// ===== rtl/m3i_cofactor.sv =====
// Pipeline front end: cofactors and determinant of a 3x3 matrix.
`default_nettype none
module m3i_cofactor (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         vld_in,
  input  m3i_pkg::m3i_in_t                  mat,
  output logic                              vld_out,
  output logic signed [m3i_pkg::CofW-1:0]   cof [9],
  output logic signed [m3i_pkg::DetW-1:0]   det
);
  import m3i_pkg::*;

  // Stage 1: the eighteen element products.
  logic signed [63:0] pa [9];
  logic signed [63:0] pb [9];
  logic               v1;
  logic signed [31:0] e1 [3];
  // Stage 2: cofactors.
  logic               v2;
  logic signed [31:0] e2 [3];
  logic signed [CofW-1:0] c2 [9];
  // Stage 3: determinant partial products on the low and high cofactor halves.
  logic signed [64:0]     pl3 [3];
  logic signed [64:0]     ph3 [3];
  logic signed [CofW-1:0] c3 [9];
  logic               v3;
  // Stage 4: determinant terms.
  logic signed [DetW-1:0] t4 [3];
  logic signed [CofW-1:0] c4 [9];
  logic               v4;

  always_ff @(posedge clk) begin
    pa[0] <= mat.a11 * mat.a22;  pb[0] <= mat.a12 * mat.a21;
    pa[1] <= mat.a02 * mat.a21;  pb[1] <= mat.a01 * mat.a22;
    pa[2] <= mat.a01 * mat.a12;  pb[2] <= mat.a02 * mat.a11;
    pa[3] <= mat.a12 * mat.a20;  pb[3] <= mat.a10 * mat.a22;
    pa[4] <= mat.a00 * mat.a22;  pb[4] <= mat.a02 * mat.a20;
    pa[5] <= mat.a02 * mat.a10;  pb[5] <= mat.a00 * mat.a12;
    pa[6] <= mat.a10 * mat.a21;  pb[6] <= mat.a11 * mat.a20;
    pa[7] <= mat.a01 * mat.a20;  pb[7] <= mat.a00 * mat.a21;
    pa[8] <= mat.a00 * mat.a11;  pb[8] <= mat.a01 * mat.a10;
    e1[0] <= mat.a00;
    e1[1] <= mat.a01;
    e1[2] <= mat.a02;
    for (int i = 0; i < 9; i++) begin
      c2[i] <= CofW'(pa[i]) - CofW'(pb[i]);
    end
    e2 <= e1;
    // Each 32 x 65 term is split into 32 x 33 products on the unsigned low
    // 32 bits and the signed high 33 bits of the cofactor.
    pl3[0] <= e2[0] * $signed({1'b0, c2[0][31:0]});
    ph3[0] <= e2[0] * $signed(c2[0][CofW-1:32]);
    pl3[1] <= e2[1] * $signed({1'b0, c2[3][31:0]});
    ph3[1] <= e2[1] * $signed(c2[3][CofW-1:32]);
    pl3[2] <= e2[2] * $signed({1'b0, c2[6][31:0]});
    ph3[2] <= e2[2] * $signed(c2[6][CofW-1:32]);
    c3 <= c2;
    for (int k = 0; k < 3; k++) begin
      t4[k] <= (DetW'(ph3[k]) <<< 32) + DetW'(pl3[k]);
    end
    c4 <= c3;
  end

  // Stage 5: determinant sum; cofactors travel alongside.
  always_ff @(posedge clk) begin
    det <= t4[0] + t4[1] + t4[2];
    cof <= c4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; vld_out <= 1'b0;
    end else begin
      v1 <= vld_in; v2 <= v1; v3 <= v2; v4 <= v3; vld_out <= v4;
    end
  end

  assert property (@(posedge clk) disable iff (rst) vld_in |-> ##5 vld_out)
    else $error("cofactor pipeline lost a transaction");
endmodule
`default_nettype wire

// ===== rtl/m3i_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, nine lanes.
`default_nettype none
module m3i_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        vld_in,
  input  wire logic [m3i_pkg::NumW-1:0]    num [9],
  input  wire logic [m3i_pkg::DetW-1:0]    den,
  input  wire logic [8:0]                  neg_in,
  input  wire logic                        sing_in,
  output logic                             vld_out,
  output logic [m3i_pkg::QW-1:0]           quo [9],
  output logic                             ovf [9],
  output logic [8:0]                       neg_out,
  output logic                             sing_out
);
  import m3i_pkg::*;

  // Quotient bits above QW-1 only flag overflow; stage s yields bit NumW-1-s.
  localparam int unsigned RemW = DetW + 1;

  logic [RemW-1:0] rem [NumW+1][9];
  logic [NumW-1:0] nsh [NumW+1][9];
  logic [QW-1:0]   q   [NumW+1][9];
  logic            of  [NumW+1][9];
  logic [DetW-1:0] d   [NumW+1];
  logic [8:0]      ng  [NumW+1];
  logic            sg  [NumW+1];
  logic            v   [NumW+1];

  always_comb begin
    for (int l = 0; l < 9; l++) begin
      rem[0][l] = '0;
      nsh[0][l] = num[l];
      q[0][l]   = '0;
      of[0][l]  = 1'b0;
    end
    d[0]  = den;
    ng[0] = neg_in;
    sg[0] = sing_in;
    v[0]  = vld_in;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [RemW-1:0] trial [9];
    logic            ge    [9];
    always_comb begin
      for (int l = 0; l < 9; l++) begin
        trial[l] = {rem[s][l][RemW-2:0], nsh[s][l][NumW-1]};
        ge[l]    = trial[l] >= {1'b0, d[s]};
      end
    end
    always_ff @(posedge clk) begin
      for (int l = 0; l < 9; l++) begin
        rem[s+1][l] <= ge[l] ? trial[l] - {1'b0, d[s]} : trial[l];
        nsh[s+1][l] <= {nsh[s][l][NumW-2:0], 1'b0};
        q[s+1][l]   <= {q[s][l][QW-2:0], ge[l]};
        of[s+1][l]  <= of[s][l] | (ge[l] & (s < NumW - QW));
      end
      d[s+1]  <= d[s];
      ng[s+1] <= ng[s];
      sg[s+1] <= sg[s];
    end
    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else     v[s+1] <= v[s];
    end
  end

  assign quo      = q[NumW];
  assign ovf      = of[NumW];
  assign neg_out  = ng[NumW];
  assign sing_out = sg[NumW];
  assign vld_out  = v[NumW];

  assert property (@(posedge clk) disable iff (rst) vld_in |-> ##96 vld_out)
    else $error("divider pipeline lost a transaction");
endmodule
`default_nettype wire

// ===== rtl/matrix3x3_inverse.sv =====
// Top level of the pipelined 3x3 fixed-point matrix inverse.
// One transaction is a 3x3 matrix of signed Q16.16 elements; the block
// returns its inverse (adjugate over determinant) in signed Q16.16, each
// element truncated toward zero and clipped with the saturated flag when it
// falls out of range; a zero determinant gives all-zero elements and the
// singular flag. busy is always low: a new matrix may be started on every
// clock, and each result appears with done high for one cycle. The pipeline
// holds five stages of products, cofactors, determinant partial products,
// determinant terms and their sum, a 96-stage restoring divider that retires
// one quotient bit per stage for all nine elements in parallel, and the sign,
// saturation and output registers. The receiver cannot stall results.
`default_nettype none
module matrix3x3_inverse (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  m3i_pkg::m3i_in_t      din,
  output logic                  done,
  output m3i_pkg::m3i_out_t     dout
);
  import m3i_pkg::*;

  assign busy = 1'b0;

  logic                   cv;
  logic signed [CofW-1:0] cof [9];
  logic signed [DetW-1:0] det;

  m3i_cofactor u_cof (
    .clk(clk), .rst(rst), .vld_in(start & ~busy), .mat(din),
    .vld_out(cv), .cof(cof), .det(det)
  );

  // Stage 6: magnitudes and signs.
  logic [NumW-1:0] num [9];
  logic [DetW-1:0] dmag;
  logic [8:0]      neg;
  logic            sing;
  logic            v5;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      // A cofactor magnitude fits 64 bits; the model keeps only those.
      num[i] <= {(cof[i][CofW-1] ? 64'(-cof[i]) : 64'(cof[i])), 32'h0};
      neg[i] <= cof[i][CofW-1] ^ det[DetW-1];
    end
    dmag <= det[DetW-1] ? DetW'(-det) : DetW'(det);
    sing <= (det == '0);
  end
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= cv;
  end

  logic            dv;
  logic [QW-1:0]   quo [9];
  logic            ovf [9];
  logic [8:0]      dneg;
  logic            dsing;

  // A zero divisor is fed as one so the divider stays well defined.
  m3i_divider u_div (
    .clk(clk), .rst(rst), .vld_in(v5), .num(num),
    .den(sing ? DetW'(1) : dmag), .neg_in(neg), .sing_in(sing),
    .vld_out(dv), .quo(quo), .ovf(ovf), .neg_out(dneg), .sing_out(dsing)
  );

  // Final stage: sign, clip and register the result.
  logic [31:0] el [9];
  logic [8:0]  clip;
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      if (dsing) begin
        el[i] = '0; clip[i] = 1'b0;
      end else if (dneg[i]) begin
        clip[i] = ovf[i] | (quo[i] > {1'b0, MinNeg});
        el[i]   = clip[i] ? MinNeg : 32'(-quo[i]);
      end else begin
        clip[i] = ovf[i] | (quo[i] > {1'b0, MaxPos});
        el[i]   = clip[i] ? MaxPos : quo[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    dout.inv00 <= el[0]; dout.inv01 <= el[1]; dout.inv02 <= el[2];
    dout.inv10 <= el[3]; dout.inv11 <= el[4]; dout.inv12 <= el[5];
    dout.inv20 <= el[6]; dout.inv21 <= el[7]; dout.inv22 <= el[8];
    dout.singular  <= dsing;
    dout.saturated <= |clip;
  end
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv;
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !(dout.singular && dout.saturated))
    else $error("singular result flagged as saturated");
  assert property (@(posedge clk) disable iff (rst)
    done && dout.singular |-> dout.inv00 == 0 && dout.inv11 == 0 && dout.inv22 == 0)
    else $error("singular result has nonzero diagonal");
  assert property (@(posedge clk) disable iff (rst) start |-> ##103 done)
    else $error("transaction lost between start and done");
endmodule
`default_nettype wire
